@@ hdl/kti_pkg.sv @@
// ============================================================================
// kti_pkg
// Shared types and constants of the keyframe track interpolator: field widths,
// operation and register codes, sequencer states and the key store ports.
// ============================================================================
package kti_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int KEY_IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 17;
    localparam int QUO_W     = 16;
    localparam int NUM_COMP  = 3;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Operation codes carried in s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_COUNT = 2'd0;
    localparam logic [1:0] CFG_MODE      = 2'd1;

    localparam logic MODE_SCALAR = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_VL,
        ST_VR,
        ST_VCAP,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } kti_state_t;

    // Write request into the key store.
    typedef struct packed {
        logic                 en;
        logic [KEY_IDX_W-1:0] idx;
        logic [TIME_W-1:0]    ktime;
        logic [VAL_W-1:0]     x;
        logic [VAL_W-1:0]     y;
        logic [VAL_W-1:0]     z;
    } kti_wr_t;

    // Registered value read of one key.
    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] z;
    } kti_val_t;

endpackage

@@ hdl/kti_key_store.sv @@
// ============================================================================
// kti_key_store
// Key time memory and three value memories, written together at one slot,
// with a registered time read port and a registered value read port.
// ============================================================================
module kti_key_store
    import kti_pkg::*;
(
    input  logic                 aclk,
    input  kti_wr_t              wr,
    input  logic [KEY_IDX_W-1:0] time_addr,
    output logic [TIME_W-1:0]    time_q,
    input  logic [KEY_IDX_W-1:0] val_addr,
    output kti_val_t             val_q
);

    logic [TIME_W-1:0] time_mem [MAX_KEYS];
    logic [VAL_W-1:0]  x_mem    [MAX_KEYS];
    logic [VAL_W-1:0]  y_mem    [MAX_KEYS];
    logic [VAL_W-1:0]  z_mem    [MAX_KEYS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            time_mem[wr.idx] <= wr.ktime;
            x_mem[wr.idx]    <= wr.x;
            y_mem[wr.idx]    <= wr.y;
            z_mem[wr.idx]    <= wr.z;
        end
    end

    always_ff @(posedge aclk) begin
        time_q  <= time_mem[time_addr];
        val_q.x <= x_mem[val_addr];
        val_q.y <= y_mem[val_addr];
        val_q.z <= z_mem[val_addr];
    end

endmodule

@@ hdl/keyframe_track_interpolator_core.sv @@
// ============================================================================
// keyframe_track_interpolator_core
// Keyframe track with linear interpolation of one or three Q16.16 components
// at a query time, driven by a small sequencer around a serial divider.
// ============================================================================
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_tvalid/s_tready   s_tuser op, s_tdata key and query
//  m_       out        m_tvalid/m_tready   m_tuser no_keys, m_tdata result
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  A key write completes in its accept cycle. A query takes its accept cycle,
//  a scan of the keys (one time memory read a cycle), the value reads of the
//  left and right keys, restoring division when the weight lies strictly
//  between zero and one (one quotient bit a cycle), a multiply and an add per
//  component, and a load of the output register. No new item is accepted
//  until the sequencer is back in idle after a query.
//  Reset is synchronous, active low, and clears control and configuration only.
//  The key memories hold whatever was written. A waiting result sits in the
//  output register; the next item is taken meanwhile, and a later result waits
//  for that register to drain.
//
module keyframe_track_interpolator_core
    import kti_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] key_index, [35:4] key_time, [67:36] key_x, [99:68] key_y,
    // [131:100] key_z, [163:132] query_time, [167:164] zero
    input  logic [167:0] s_tdata,
    // [0] op
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] value_x, [63:32] value_y, [95:64] value_z, [99:96] segment,
    // [116:100] fraction, [119:117] zero
    output logic [119:0] m_tdata,
    // [0] no_keys
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    kti_state_t state_reg, state_next;

    logic [CNT_W-1:0]     key_count_reg;
    logic                 mode_reg;
    logic [CNT_W-1:0]     n_eff;

    logic [KEY_IDX_W-1:0] in_idx;
    logic [TIME_W-1:0]    in_time, in_qt;
    logic [VAL_W-1:0]     in_x, in_y, in_z;
    logic                 s_acc;

    kti_wr_t              wr;
    logic [KEY_IDX_W-1:0] time_addr, val_addr;
    logic [TIME_W-1:0]    time_q;
    kti_val_t             val_q;

    logic [TIME_W-1:0]    qt_reg, t0_reg, prev_reg, lt_reg, rt_reg;
    logic [KEY_IDX_W-1:0] k_reg, cur_reg, nxt_reg;
    logic [TIME_W:0]      diff_reg, span_reg;
    logic [TIME_W-1:0]    rem_reg, as_reg;
    logic [3:0]           div_cnt_reg;
    logic [FRAC_W-1:0]    t_reg;
    logic [1:0]           comp_reg;
    kti_val_t             lval_reg, rval_reg;
    logic signed [50:0]   prod_reg;
    logic [VAL_W-1:0]     res_x_reg, res_y_reg, res_z_reg;
    logic [KEY_IDX_W-1:0] seg_reg;
    logic                 nokeys_reg;

    logic                 out_valid_reg;
    logic [119:0]         out_data_reg;
    logic                 out_user_reg;

    logic                 hit, last_pair;
    logic [TIME_W:0]      diff_mag, span_mag;
    logic [TIME_W-1:0]    ad, as_w;
    logic                 weight_ok, div_go;
    logic [TIME_W:0]      r2, rsub;
    logic                 r_ge;
    logic [VAL_W-1:0]     l_sel, r_sel;
    logic signed [32:0]   dsub;
    logic signed [17:0]   t_s;
    logic signed [50:0]   mul_w;
    logic [VAL_W-1:0]     sum_w;
    logic                 comp_last;
    logic                 out_free, load_out;

    assign in_idx  = s_tdata[3:0];
    assign in_time = s_tdata[35:4];
    assign in_x    = s_tdata[67:36];
    assign in_y    = s_tdata[99:68];
    assign in_z    = s_tdata[131:100];
    assign in_qt   = s_tdata[163:132];

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = aresetn;
    assign n_eff     = (key_count_reg > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
            mode_reg      <= MODE_SCALAR;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_COUNT: key_count_reg <= cfg_data[CNT_W-1:0];
                CFG_MODE:      mode_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Writes beyond the active key count are dropped.
    always_comb begin
        wr.en    = s_acc && (s_tuser == OP_WRITE) && ({1'b0, in_idx} < n_eff);
        wr.idx   = in_idx;
        wr.ktime = in_time;
        wr.x     = in_x;
        wr.y     = in_y;
        wr.z     = in_z;
    end

    kti_key_store u_store (
        .aclk      (aclk),
        .wr        (wr),
        .time_addr (time_addr),
        .time_q    (time_q),
        .val_addr  (val_addr),
        .val_q     (val_q)
    );

    // Segment test: time_q holds the time of key k, prev_reg that of key k-1.
    assign hit       = (prev_reg <= qt_reg) && (time_q > qt_reg);
    assign last_pair = ({1'b0, k_reg} == (n_eff - CNT_W'(1)));

    always_comb begin
        diff_mag  = diff_reg[TIME_W] ? (~diff_reg + 33'd1) : diff_reg;
        span_mag  = span_reg[TIME_W] ? (~span_reg + 33'd1) : span_reg;
        ad        = diff_mag[TIME_W-1:0];
        as_w      = span_mag[TIME_W-1:0];
        weight_ok = (span_reg != '0) && (diff_reg != '0) &&
                    (diff_reg[TIME_W] == span_reg[TIME_W]);
        div_go    = weight_ok && (ad < as_w);
    end

    assign r2   = {rem_reg, 1'b0};
    assign r_ge = (r2 >= {1'b0, as_reg});
    assign rsub = r2 - {1'b0, as_reg};

    always_comb begin
        unique case (comp_reg)
            COMP_Y: begin
                l_sel = lval_reg.y;
                r_sel = rval_reg.y;
            end
            COMP_Z: begin
                l_sel = lval_reg.z;
                r_sel = rval_reg.z;
            end
            default: begin
                l_sel = lval_reg.x;
                r_sel = rval_reg.x;
            end
        endcase
    end

    // Arithmetic shift of the product gives the floor of product / 65536.
    assign dsub      = $signed({r_sel[VAL_W-1], r_sel}) - $signed({l_sel[VAL_W-1], l_sel});
    assign t_s       = $signed({1'b0, t_reg});
    assign mul_w     = dsub * t_s;
    assign sum_w     = l_sel + prod_reg[47:16];
    assign comp_last = (comp_reg == COMP_Z) ||
                       ((mode_reg == MODE_SCALAR) && (comp_reg == COMP_X));

    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        time_addr  = '0;
        val_addr   = cur_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_acc && (s_tuser == OP_QUERY)) begin
                    state_next = (n_eff == '0) ? ST_DONE : ST_FIRST;
                end
            end
            ST_FIRST: begin
                time_addr  = KEY_IDX_W'(1);
                state_next = (n_eff == CNT_W'(1)) ? ST_VL : ST_SCAN;
            end
            ST_SCAN: begin
                time_addr = k_reg + KEY_IDX_W'(1);
                if (hit || last_pair) begin
                    state_next = ST_VL;
                end
            end
            ST_VL: begin
                val_addr   = cur_reg;
                state_next = ST_VR;
            end
            ST_VR: begin
                val_addr   = nxt_reg;
                state_next = ST_VCAP;
            end
            ST_VCAP: begin
                state_next = div_go ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                if (div_cnt_reg == 4'd15) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = comp_last ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == OP_QUERY)) begin
                    qt_reg     <= in_qt;
                    res_x_reg  <= '0;
                    res_y_reg  <= '0;
                    res_z_reg  <= '0;
                    seg_reg    <= '0;
                    t_reg      <= '0;
                    nokeys_reg <= (n_eff == '0);
                end
            end
            ST_FIRST: begin
                t0_reg   <= time_q;
                prev_reg <= time_q;
                k_reg    <= KEY_IDX_W'(1);
                cur_reg  <= '0;
                nxt_reg  <= '0;
                lt_reg   <= time_q;
                rt_reg   <= time_q;
            end
            ST_SCAN: begin
                if (hit) begin
                    cur_reg <= k_reg - KEY_IDX_W'(1);
                    nxt_reg <= k_reg;
                    lt_reg  <= prev_reg;
                    rt_reg  <= time_q;
                end else if (last_pair) begin
                    // No segment holds the query: fall back to the last-to-first pair.
                    cur_reg <= k_reg;
                    nxt_reg <= '0;
                    lt_reg  <= time_q;
                    rt_reg  <= t0_reg;
                end else begin
                    prev_reg <= time_q;
                    k_reg    <= k_reg + KEY_IDX_W'(1);
                end
            end
            ST_VL: begin
                diff_reg <= {1'b0, qt_reg} - {1'b0, lt_reg};
                span_reg <= {1'b0, rt_reg} - {1'b0, lt_reg};
            end
            ST_VR: begin
                lval_reg <= val_q;
            end
            ST_VCAP: begin
                rval_reg    <= val_q;
                res_y_reg   <= '0;
                res_z_reg   <= '0;
                seg_reg     <= cur_reg;
                nokeys_reg  <= 1'b0;
                comp_reg    <= COMP_X;
                rem_reg     <= ad;
                as_reg      <= as_w;
                div_cnt_reg <= '0;
                // A ratio of one or more clamps to one; a bad sign or zero span gives zero.
                if (!weight_ok) begin
                    t_reg <= '0;
                end else if (ad >= as_w) begin
                    t_reg <= FRAC_ONE;
                end else begin
                    t_reg <= '0;
                end
            end
            ST_DIV: begin
                if (r_ge) begin
                    rem_reg <= rsub[TIME_W-1:0];
                end else begin
                    rem_reg <= r2[TIME_W-1:0];
                end
                t_reg       <= {1'b0, t_reg[QUO_W-2:0], r_ge};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            ST_MUL: begin
                prod_reg <= mul_w;
            end
            ST_ADD: begin
                unique case (comp_reg)
                    COMP_Y:  res_y_reg <= sum_w;
                    COMP_Z:  res_z_reg <= sum_w;
                    default: res_x_reg <= sum_w;
                endcase
                comp_reg <= comp_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {3'b000, t_reg, seg_reg, res_z_reg, res_y_reg, res_x_reg};
            out_user_reg <= nokeys_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // During division the partial remainder stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < as_reg))
        else $error("divider remainder not below divisor");

    // An empty track reports zero segment and weight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[116:96] == '0))
        else $error("no_keys result with nonzero segment or fraction");

    // The weight never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[116:100] <= FRAC_ONE))
        else $error("fraction above one");

    // A query on a nonempty track starts the scan at the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == OP_QUERY) && (n_eff != '0)) |=> (state_reg == ST_FIRST))
        else $error("query did not start the key scan");

endmodule
